// File: rtl/ppmq_pkg.sv
// ----------------------------------------------------------------------------
// ppmq_pkg: shared types and constants of the per-process mailbox
// Sizes, item and result structs, status and state codes, and the small
// helper functions used by the datapath.
// ----------------------------------------------------------------------------
package ppmq_pkg;

  localparam int unsigned QUEUE_SLOTS   = 10;
  localparam int unsigned PROCESS_COUNT = 8;
  localparam int unsigned MESSAGE_LIMIT = 8;

  localparam int unsigned PtrW   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned ProcW  = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int unsigned Depth  = PROCESS_COUNT * QUEUE_SLOTS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_RECV = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_TOO_LONG = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  caller_id;
    logic [2:0]  receiver_id;
    logic [7:0]  message_length;
    logic [63:0] message_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  sender_id;
    logic [3:0]  out_length;
    logic [63:0] out_data;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  sender;
    logic [3:0]  length;
    logic [63:0] data;
  } slot_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Reduces a process id modulo the process count by repeated subtraction.
  function automatic logic [2:0] pick_process(input logic [2:0] id);
    logic [6:0] v;
    v = {4'b0000, id};
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(PROCESS_COUNT)) begin
        v = v - 7'(PROCESS_COUNT);
      end
    end
    return v[2:0];
  endfunction

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_SLOTS - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] prev_slot(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(QUEUE_SLOTS - 1) : p - PtrW'(1);
  endfunction

endpackage

// File: rtl/ppmq_ctrl.sv
// ----------------------------------------------------------------------------
// ppmq_ctrl: sequencing of one mailbox operation
// Takes an item, runs the queue update, then hands the result to the
// output register as soon as it is free.
// ----------------------------------------------------------------------------
module ppmq_ctrl
  import ppmq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      S_LOAD: begin
        cmd_o.load = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/ppmq_dp.sv
// ----------------------------------------------------------------------------
// ppmq_dp: queue pointers, slot memory and result register
// Holds the head and tail of every queue, the shared slot store and the
// output register that carries one result beat.
// ----------------------------------------------------------------------------
module ppmq_dp
  import ppmq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  in_item_t          item_q;
  logic [PtrW-1:0]   head_q [PROCESS_COUNT];
  logic [PtrW-1:0]   tail_q [PROCESS_COUNT];
  slot_t             mem    [Depth];
  slot_t             rd_q;
  logic [1:0]        res_status_q;
  logic              res_read_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [2:0]        caller;
  logic [2:0]        receiver;
  logic [ProcW-1:0]  qid;
  logic [PtrW-1:0]   head;
  logic [PtrW-1:0]   tail;
  logic              is_send;
  logic              too_long;
  logic              full;
  logic              empty;
  logic              do_write;
  logic              do_read;
  logic [1:0]        exec_status;
  logic [AddrW-1:0]  addr;
  logic [63:0]       mask;
  slot_t             wr_slot;

  always_comb begin
    caller   = pick_process(item_q.caller_id);
    receiver = pick_process(item_q.receiver_id);
    is_send  = (item_q.kind == KIND_SEND);
    qid      = is_send ? ProcW'(receiver) : ProcW'(caller);
    head     = head_q[qid];
    tail     = tail_q[qid];
    too_long = (item_q.message_length >= 8'(MESSAGE_LIMIT - 1));
    full     = (tail == prev_slot(head));
    empty    = (head == tail);
    if (is_send) begin
      exec_status = too_long ? STAT_TOO_LONG : (full ? STAT_FULL : STAT_OK);
    end else begin
      exec_status = empty ? STAT_EMPTY : STAT_OK;
    end
    do_write = cmd_i.exec && is_send && !too_long && !full;
    do_read  = cmd_i.exec && !is_send && !empty;
    addr     = AddrW'(qid) * AddrW'(QUEUE_SLOTS) + AddrW'(is_send ? tail : head);
    mask     = (64'd1 << {item_q.message_length[2:0], 3'b000}) - 64'd1;
    wr_slot.sender = caller;
    wr_slot.length = item_q.message_length[3:0];
    wr_slot.data   = item_q.message_data & mask;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (do_write) mem[addr] <= wr_slot;
    if (do_read) rd_q <= mem[addr];
    if (cmd_i.exec) begin
      res_status_q <= exec_status;
      res_read_q   <= do_read;
    end
    if (cmd_i.load) begin
      out_q.status <= res_status_q;
      if (res_read_q) begin
        out_q.sender_id  <= rd_q.sender;
        out_q.out_length <= rd_q.length;
        out_q.out_data   <= rd_q.data;
      end else begin
        out_q.sender_id  <= '0;
        out_q.out_length <= '0;
        out_q.out_data   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROCESS_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      if (do_write) tail_q[qid] <= next_slot(tail);
      if (do_read) head_q[qid] <= next_slot(head);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// File: rtl/per_process_mailbox_queues_top.sv
// A result beat becomes valid once its item has passed the controller sequence
// of capture, queue update and result load; the slot memory read is registered.
// A new item is taken only after the last result is loaded, and that load waits for a free output register.
// A waiting result does not block the next item, which is taken meanwhile.
// Reset is asynchronous and active low; it empties every queue at once.
// ----------------------------------------------------------------------------
// per_process_mailbox_queues_top: per-process mailbox with ring queues
// Send beats append a message to the receiver's queue; receive beats pop
// the caller's own queue. Each item yields exactly one result beat.
// ----------------------------------------------------------------------------
module per_process_mailbox_queues_top
  import ppmq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  ppmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  ppmq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/ppmq_checker.sv
// ----------------------------------------------------------------------------
// ppmq_checker: port-level checks of the mailbox
// Watches the top level's channels and flags results that break the
// block's rules; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module ppmq_checker
  import ppmq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result beat changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input taken again right after an accepted beat.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != STAT_OK) |->
      (out_item_o.sender_id == '0) && (out_item_o.out_length == '0) &&
      (out_item_o.out_data == '0))
    else $error("Failed operation returned nonzero payload.");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_length < 4'(MESSAGE_LIMIT - 1)))
    else $error("Received length exceeds the message limit.");

endmodule

bind per_process_mailbox_queues_top ppmq_checker u_ppmq_checker (.*);
